/* rtl/gilbert_moore_code_builder_unit_assert.svh */
// Assertion macros for the Gilbert-Moore code builder.
// Used by files that need clk_i and rst_ni in scope.
`ifndef GILBERT_MOORE_CODE_BUILDER_UNIT_ASSERT_SVH
`define GILBERT_MOORE_CODE_BUILDER_UNIT_ASSERT_SVH

// Checked only out of reset.
`define GMCB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define GMCB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/gmcb_pkg.sv */
// Shared constants and control types of the Gilbert-Moore code builder.
// No dependencies.
`timescale 1ns / 1ps

package gmcb_pkg;

  localparam int COUNT_BITS_DEF    = 20;
  localparam int MAX_CODE_BITS_DEF = 24;
  localparam int LEN_W             = 5;   // code_length field
  localparam int CODE_W            = 24;  // code_value field

  // controller -> datapath
  typedef struct packed {
    logic load;         // input transfer: capture item
    logic search_step;  // remainder and length search step
    logic code_step;    // one code bit
    logic out_load;     // move result to output register
  } gmcb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic search_done;
    logic code_done;
  } gmcb_stat_t;

endpackage

/* rtl/gmcb_channels.sv */
// Valid/ready channel interfaces: symbol input, code output, total_count config.
// Depends on gmcb_pkg.
`timescale 1ns / 1ps

interface gmcb_in_if #(
  parameter int COUNT_BITS = gmcb_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS:0]   symbol_count;
  logic                  last_symbol;

  modport source (output valid, symbol_count, last_symbol, input ready);
  modport sink   (input valid, symbol_count, last_symbol, output ready);
endinterface

interface gmcb_out_if;
  logic                        valid;
  logic                        ready;
  logic [gmcb_pkg::LEN_W-1:0]  code_length;
  logic [gmcb_pkg::CODE_W-1:0] code_value;

  modport source (output valid, code_length, code_value, input ready);
  modport sink   (input valid, code_length, code_value, output ready);
endinterface

interface gmcb_cfg_if #(
  parameter int COUNT_BITS = gmcb_pkg::COUNT_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [COUNT_BITS:0] total_count;

  modport source (output valid, total_count, input ready);
  modport sink   (input valid, total_count, output ready);
endinterface

/* rtl/gmcb_ctrl.sv */
// Sequencer of the Gilbert-Moore code builder: phases and output valid.
// Depends on gmcb_pkg.
`timescale 1ns / 1ps

module gmcb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  gmcb_pkg::gmcb_stat_t stat_i,
  output gmcb_pkg::gmcb_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CODE,
    ST_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (stat_i.search_done) begin
          state_d = ST_CODE;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      ST_CODE: begin
        if (stat_i.code_done) begin
          state_d = ST_HOLD;
        end else begin
          cmd_o.code_step = 1'b1;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/gmcb_datapath.sv */
// Datapath of the Gilbert-Moore code builder: running count, remainder,
// length search, bit-serial code division and result register. Depends on gmcb_pkg.
`timescale 1ns / 1ps

module gmcb_datapath #(
  parameter int COUNT_BITS    = gmcb_pkg::COUNT_BITS_DEF,
  parameter int MAX_CODE_BITS = gmcb_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gmcb_pkg::gmcb_cmd_t         cmd_i,
  output gmcb_pkg::gmcb_stat_t        stat_o,
  input  logic [COUNT_BITS:0]         symbol_count_i,
  input  logic                        last_symbol_i,
  input  logic                        cfg_we_i,
  input  logic [COUNT_BITS:0]         total_count_i,
  output logic [gmcb_pkg::LEN_W-1:0]  code_length_o,
  output logic [gmcb_pkg::CODE_W-1:0] code_value_o
);

  localparam int CW     = COUNT_BITS + 1;          // count width
  localparam int NW     = CW + 2;                  // numerator 2*cum+cnt
  localparam int DW     = CW + 1;                  // denominator 2*total
  localparam int MCW    = $clog2(NW + 1);
  localparam int LW     = $clog2(MAX_CODE_BITS + 1);
  localparam int LEN_W  = gmcb_pkg::LEN_W;
  localparam int CODE_W = gmcb_pkg::CODE_W;

  logic [CW-1:0]            tot_q, cum_q, tot_eff;
  logic [NW-1:0]            num_q;
  logic [MCW-1:0]           mod_cnt_q;
  logic [DW-1:0]            rem_q, den, v_q;
  logic [LW-1:0]            len_q, idx_q;
  logic [MAX_CODE_BITS-1:0] code_q;
  logic [LEN_W-1:0]         code_length_q;
  logic [CODE_W-1:0]        code_value_q;

  logic [DW:0] mod_sh, mod_sub, cod_sh, cod_sub;
  logic        mod_ge, cod_ge, mod_active, len_active;

  // a total of zero acts as one
  assign tot_eff = (tot_q == '0) ? CW'(1) : tot_q;
  assign den     = {tot_eff, 1'b0};

  // remainder of the numerator, one numerator bit per step
  assign mod_sh  = {rem_q, num_q[NW-1]};
  assign mod_sub = mod_sh - {1'b0, den};
  assign mod_ge  = (mod_sh >= {1'b0, den});

  // code bits: doubled remainder against the denominator
  assign cod_sh  = {rem_q, 1'b0};
  assign cod_sub = cod_sh - {1'b0, den};
  assign cod_ge  = (cod_sh >= {1'b0, den});

  assign mod_active = (mod_cnt_q != '0);
  assign len_active = (v_q != '0) && (v_q < {1'b0, tot_eff}) &&
                      (len_q < LW'(MAX_CODE_BITS));

  assign stat_o.search_done = !mod_active && !len_active;
  assign stat_o.code_done   = (idx_q == len_q);

  assign code_length_o = code_length_q;
  assign code_value_o  = code_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q     <= CW'(1);
      cum_q     <= '0;
      mod_cnt_q <= '0;
      len_q     <= '0;
      idx_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        tot_q <= total_count_i;
      end
      if (cmd_i.load) begin
        cum_q     <= last_symbol_i ? '0 : CW'(cum_q + symbol_count_i);
        mod_cnt_q <= MCW'(NW);
        len_q     <= (symbol_count_i != '0) ? LW'(1) : '0;
        idx_q     <= '0;
      end
      if (cmd_i.search_step) begin
        if (mod_active) begin
          mod_cnt_q <= mod_cnt_q - MCW'(1);
        end
        if (len_active) begin
          len_q <= len_q + LW'(1);
        end
      end
      if (cmd_i.code_step) begin
        idx_q <= idx_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q  <= NW'({cum_q, 1'b0}) + NW'(symbol_count_i);
      rem_q  <= '0;
      v_q    <= DW'(symbol_count_i);
      code_q <= '0;
    end
    if (cmd_i.search_step) begin
      if (mod_active) begin
        rem_q <= mod_ge ? DW'(mod_sub) : DW'(mod_sh);
        num_q <= {num_q[NW-2:0], 1'b0};
      end
      if (len_active) begin
        v_q <= {v_q[DW-2:0], 1'b0};
      end
    end
    if (cmd_i.code_step) begin
      rem_q  <= cod_ge ? DW'(cod_sub) : DW'(cod_sh);
      code_q <= {code_q[MAX_CODE_BITS-2:0], cod_ge};
    end
    if (cmd_i.out_load) begin
      code_length_q <= LEN_W'(len_q);
      code_value_q  <= CODE_W'(code_q);
    end
  end

endmodule

/* rtl/gilbert_moore_code_builder_unit.sv */
// Gilbert-Moore alphabetic code builder: one item in, one code out. Each
// item passes through two bit-serial loops on one shared remainder
// register: first the numerator 2*cum+count is reduced modulo 2*total,
// one numerator bit per cycle, with the code length search running
// alongside it; then the code is formed one quotient bit per cycle by
// restoring division. The finished code sits in an output register,
// so a new symbol is taken while the previous result still waits for its
// transfer. total_count is written through the configuration channel, which
// is always ready; write it only while no symbol is in flight. Depends on
// gmcb_pkg, gmcb_channels, gmcb_ctrl, gmcb_datapath and the assertion header.
`timescale 1ns / 1ps

`include "gilbert_moore_code_builder_unit_assert.svh"

module gilbert_moore_code_builder_unit #(
  parameter int COUNT_BITS    = gmcb_pkg::COUNT_BITS_DEF,
  parameter int MAX_CODE_BITS = gmcb_pkg::MAX_CODE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gmcb_in_if.sink    in_i,    // symbol_count, last_symbol
  gmcb_out_if.source out_o,   // code_length, code_value
  gmcb_cfg_if.sink   cfg_i    // total_count
);

  gmcb_pkg::gmcb_cmd_t  cmd;
  gmcb_pkg::gmcb_stat_t stat;

  // register write needs no back pressure
  assign cfg_i.ready = 1'b1;

  // phase sequencing and output valid
  gmcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // counts, remainder, length, code bits and the result register
  gmcb_datapath #(
    .COUNT_BITS    (COUNT_BITS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .symbol_count_i (in_i.symbol_count),
    .last_symbol_i  (in_i.last_symbol),
    .cfg_we_i       (cfg_i.valid),
    .total_count_i  (cfg_i.total_count),
    .code_length_o  (out_o.code_length),
    .code_value_o   (out_o.code_value)
  );

  // a transfer in starts the search, so the input closes for the next cycle
  `GMCB_ASSERT(a_busy_after_in, in_i.valid && in_i.ready |=> !in_i.ready, "input open during work")
  // the result register is only overwritten when its content is gone
  `GMCB_ASSERT_ALWAYS(a_out_slot_free, cmd.out_load |-> (!out_o.valid || out_o.ready), "result lost")
  // code bits are only formed on a fully reduced remainder and a final length
  `GMCB_ASSERT(a_code_after_search, cmd.code_step |-> stat.search_done, "code before search end")
  // a result is loaded only after all its code bits
  `GMCB_ASSERT(a_load_after_code, cmd.out_load |-> stat.code_done, "result before code end")

endmodule

/* tb/tb.sv */
// Self-checking bench for gilbert_moore_code_builder_unit: symbol counts are driven over
// valid/ready with random gaps and stalls, and each code is checked against a bit-exact predictor.
// Depends on gmcb_pkg, gmcb_channels and the block's RTL.
`timescale 1ns / 1ps

module tb;

  localparam int CB       = gmcb_pkg::COUNT_BITS_DEF;  // count fields are CB+1 bits wide
  localparam int CW       = CB + 1;
  localparam int MCB      = gmcb_pkg::MAX_CODE_BITS_DEF;
  localparam int HOLD_LEN = 600;                // long receiver hold-off, in cycles
  localparam int TAIL_LEN = 64;                 // longer than one worst-case item
  localparam int LIMIT    = 700000;
  localparam logic [CB:0] CNT_MAX = '1;

  typedef struct packed {
    logic [CB:0] count;
    logic        last;
  } symbol_t;

  typedef struct packed {
    logic [gmcb_pkg::LEN_W-1:0]  len;
    logic [gmcb_pkg::CODE_W-1:0] value;
  } code_t;

  logic clk_i;
  logic rst_ni;

  gmcb_in_if  #(.COUNT_BITS(CB)) sym_if ();
  gmcb_out_if                    code_if ();
  gmcb_cfg_if #(.COUNT_BITS(CB)) cfg_if ();

  gilbert_moore_code_builder_unit #(
    .COUNT_BITS   (CB),
    .MAX_CODE_BITS(MCB)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (sym_if),
    .out_o (code_if),
    .cfg_i (cfg_if)
  );

  // Bench-side copy of the block's state and its one register.
  logic [CB:0] cum_count = '0;
  logic [CB:0] total_reg = 1;

  symbol_t     pending_symbols[$];
  code_t       expected_codes[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;

  // Knobs set by the stimulus sequence.
  bit no_idle   = 1'b0;   // tail of the run: neither side idles
  bit hold_req  = 1'b0;   // request the long receiver hold-off
  bit hold_done = 1'b0;
  int unsigned hold_cnt = 0;

  logic in_taken = 1'b0;  // an input transfer happened at the last rising edge
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  // Predictor: code length is the least L with count*2^L >= total, plus one,
  // clamped; code bits come from exact long division of the midpoint
  // (2*cum + count) / (2*total), keeping only its fractional part.
  function automatic code_t encode_symbol(logic [CB:0] cnt, logic [CB:0] cum,
                                          logic [CB:0] tot_reg);
    logic [63:0] tot;
    logic [63:0] scaled;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] bits;
    int          len;
    code_t       res;
    res = '0;
    tot = (tot_reg == 0) ? 64'd1 : 64'(tot_reg);   // zero total acts as one
    if (cnt != 0) begin
      scaled = 64'(cnt);
      len    = 1;
      while (scaled < tot && len < MCB) begin
        scaled = scaled << 1;
        len++;
      end
      den  = 2 * tot;
      rem  = (2 * 64'(cum) + 64'(cnt)) % den;
      bits = '0;
      for (int i = 0; i < len; i++) begin
        rem  = rem << 1;
        bits = bits << 1;
        if (rem >= den) begin
          rem  = rem - den;
          bits = bits | 64'd1;
        end
      end
      res.len   = len[gmcb_pkg::LEN_W-1:0];
      res.value = bits[gmcb_pkg::CODE_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, code_t want, code_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected len %0d code %06h, got len %0d code %06h",
               $realtime, what, want.len, want.value, seen.len, seen.value);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The single reset at the start of the run.
  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("gilbert_moore_code_builder_unit test failed");
      $finish;
    end
  end

  // Monitor: all transfers are seen at the rising edge. Outputs are checked
  // before the accepted input is predicted; the block's latency keeps the two
  // apart anyway.
  always @(posedge clk_i) begin
    code_t seen;
    code_t want;
    in_taken <= rst_ni && sym_if.valid && sym_if.ready;
    if (rst_ni) begin
      if (code_if.valid && code_if.ready) begin
        seen.len   = code_if.code_length;
        seen.value = code_if.code_value;
        if (expected_codes.size() == 0) begin
          report_mismatch("code with none pending", '0, seen);
        end else begin
          want = expected_codes.pop_front();
          if (seen.len !== want.len || seen.value !== want.value)
            report_mismatch("code mismatch", want, seen);
        end
      end
      if (sym_if.valid && sym_if.ready) begin
        expected_codes.push_back(encode_symbol(sym_if.symbol_count, cum_count, total_reg));
        // cumulative count wraps at the field width and clears after last
        if (sym_if.last_symbol)
          cum_count = '0;
        else
          cum_count = cum_count + sym_if.symbol_count;
      end
      if (cfg_if.valid && cfg_if.ready)
        total_reg = cfg_if.total_count;
    end
  end

  // Symbol driver: takes the next item off the pending queue once the current
  // one has transferred, with random gap bursts in between.
  always @(negedge clk_i) begin
    symbol_t nxt;
    logic    offer;
    nxt   = '0;
    offer = 1'b0;
    if (!rst_ni) begin
      sym_if.valid        <= 1'b0;
      sym_if.symbol_count <= '0;
      sym_if.last_symbol  <= 1'b0;
    end else if (!sym_if.valid || in_taken) begin
      if (no_idle)
        send_gap = 0;
      else if (in_taken && $urandom_range(0, 3) == 0)
        send_gap = $urandom_range(1, 15);
      if (send_gap != 0) begin
        send_gap--;
      end else if (pending_symbols.size() != 0) begin
        nxt   = pending_symbols.pop_front();
        offer = 1'b1;
      end
      sym_if.valid <= offer;
      if (offer) begin
        sym_if.symbol_count <= nxt.count;
        sym_if.last_symbol  <= nxt.last;
      end
    end
  end

  // Long hold-off counter, kept apart from the ready driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Code receiver: ready with random stall bursts.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_cnt != 0) begin
      code_if.ready <= 1'b0;
    end else if (no_idle) begin
      recv_gap = 0;
      code_if.ready <= 1'b1;
    end else if (recv_gap != 0) begin
      recv_gap--;
      code_if.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(1, 15) - 1;
      code_if.ready <= 1'b0;
    end else begin
      code_if.ready <= 1'b1;
    end
  end

  task automatic add_symbol(logic [CB:0] cnt, logic last);
    symbol_t s;
    s.count = cnt;
    s.last  = last;
    pending_symbols.push_back(s);
  endtask

  // Block until every queued symbol has transferred and every code is back.
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_symbols.size() != 0 || sym_if.valid || expected_codes.size() != 0)
      @(posedge clk_i);
  endtask

  // Only called with the block drained; the channel is always ready but the
  // handshake is still honored.
  task automatic write_total(logic [CB:0] value);
    @(negedge clk_i);
    cfg_if.valid       <= 1'b1;
    cfg_if.total_count <= value;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly full alphabets whose counts sum to the total, with zero counts
  // mixed in; some alphabets lose their last mark, and some items are noise.
  task automatic queue_alphabets(logic [CB:0] total, int unsigned n);
    int unsigned made;
    int unsigned syms;
    int unsigned remaining;
    int unsigned cnt;
    bit          broken;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 4) == 0) begin
        syms = $urandom_range(1, 6);
        for (int i = 0; i < syms; i++)
          add_symbol(CW'($urandom_range(0, CNT_MAX)), $urandom_range(0, 3) == 0);
      end else begin
        syms      = $urandom_range(1, 10);
        remaining = (total == 0) ? 1 : 32'(total);
        broken    = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < syms; i++) begin
          if (i == syms - 1)
            cnt = remaining;
          else if ($urandom_range(0, 5) == 0)
            cnt = 0;
          else
            cnt = $urandom_range(0, remaining / $urandom_range(1, 4));
          remaining -= cnt;
          add_symbol(CW'(cnt), (i == syms - 1) && !broken);
        end
      end
      made += syms;
    end
  endtask

  initial begin
    logic [CB:0] total;
    cfg_if.valid       = 1'b0;
    cfg_if.total_count = '0;
    @(posedge rst_ni);

    // Directed: reset total of one, so every nonzero count is at or above
    // the total; cumulative count runs past the total and wraps.
    add_symbol(0, 1'b0);
    add_symbol(1, 1'b0);
    add_symbol(2, 1'b0);
    add_symbol(CNT_MAX, 1'b0);
    add_symbol(5, 1'b1);
    wait_drained();

    // zero total acts as one
    write_total(0);
    add_symbol(3, 1'b0);
    add_symbol(0, 1'b1);
    add_symbol(7, 1'b1);
    wait_drained();

    // largest nominal total: count 1 gets the longest code, still under the length clamp
    write_total(21'h100000);
    add_symbol(1, 1'b0);
    add_symbol(21'h100000, 1'b0);
    add_symbol(0, 1'b0);
    add_symbol(3, 1'b0);
    add_symbol(21'h0FFFFF, 1'b0);
    add_symbol(12345, 1'b1);
    wait_drained();

    // field maximum total
    write_total(CNT_MAX);
    add_symbol(CNT_MAX, 1'b0);
    add_symbol(CNT_MAX, 1'b0);
    add_symbol(1, 1'b0);
    add_symbol(0, 1'b1);
    wait_drained();

    // tiny alphabet of equal counts
    write_total(3);
    add_symbol(1, 1'b0);
    add_symbol(1, 1'b0);
    add_symbol(1, 1'b1);
    wait_drained();

    // Random phases, each with its own total.
    for (int p = 0; p < 12; p++) begin
      case (p % 6)
        0:       total = CW'($urandom_range(1, 16));
        1:       total = 21'h100000;
        2:       total = CW'($urandom_range(1, 21'h100000));
        3:       total = CNT_MAX;
        4:       total = CW'($urandom_range(0, 2));
        default: total = CW'($urandom_range(0, CNT_MAX));
      endcase
      write_total(total);
      if (p == 11)
        no_idle = 1'b1;
      if (p == 2)
        hold_req = 1'b1;   // receiver stops while the sender keeps offering
      queue_alphabets(total, 136);
      wait_drained();
    end

    repeat (TAIL_LEN) @(posedge clk_i);
    if (mismatches == 0 && expected_codes.size() == 0)
      $display("gilbert_moore_code_builder_unit test passed");
    else
      $display("gilbert_moore_code_builder_unit test failed");
    $finish;
  end

endmodule
